// ===== hw/rtl/rm2q_pkg.sv =====
// Shared types, constants and saturation helper for the matrix to quaternion converter.
`timescale 1ns / 1ps
package rm2q_pkg;

    localparam int DATA_W    = 16;
    localparam int PAIR_W    = 17;
    localparam int QUOT_BITS = 18;

    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;
    localparam logic [1:0] IDX_W = 2'd3;

    localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;
    localparam logic [QUOT_BITS-1:0] POS_LIMIT = 18'd32767;
    localparam logic [QUOT_BITS-1:0] NEG_LIMIT = 18'd32768;

    typedef struct packed {
        logic              sign;
        logic [PAIR_W-1:0] mag;
    } lane_t;

    typedef struct packed {
        lane_t [2:0] lane;
        logic [1:0]  best;
        logic        invalid;
    } side_t;

    typedef struct packed {
        logic [2:0]  sign;
        logic [1:0]  best;
        logic        invalid;
        logic [DATA_W-1:0] vq;
    } meta_t;

    function automatic logic signed [DATA_W-1:0] sat_lane(
        input logic                 sign,
        input logic [QUOT_BITS-1:0] q,
        input logic                 ovf
    );
        logic signed [DATA_W-1:0] r;
        if (!sign)
        begin
            r = (ovf || (q > POS_LIMIT)) ? Q_MAX : $signed(q[DATA_W-1:0]);
        end
        else
        begin
            r = (ovf || (q > NEG_LIMIT)) ? Q_MIN : $signed(~q[DATA_W-1:0] + 16'd1);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rm2q_if.sv =====
// Request interfaces for the matrix input and the quaternion output.
`timescale 1ns / 1ps
interface rm2q_mat_if;
    logic valid;
    logic ready;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rm2q_quat_if;
    logic valid;
    logic ready;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic [1:0] largest_index;
    logic invalid;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, largest_index, invalid,
                    input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, largest_index, invalid,
                  output ready);
endinterface

// ===== hw/rtl/rm2q_select.sv =====
// Diagonal terms, largest term choice and pair selection, two stages.
`timescale 1ns / 1ps
module rm2q_select #(
    parameter int FRAC_BITS = 14,
    parameter int EW = 20,
    parameter int NW = 31
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output logic out_valid,
    output logic [NW-1:0] n_out,
    output rm2q_pkg::side_t side_out
);
    localparam int PW = rm2q_pkg::PAIR_W;
    localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

    logic v1_reg, v2_reg;
    logic signed [EW-1:0] e_reg [4];
    logic signed [PW-1:0] sxy_reg, sxz_reg, syz_reg, dx_reg, dy_reg, dz_reg;
    logic [NW-1:0] n_reg, n_next;
    rm2q_pkg::side_t side_reg, side_next;

    logic signed [EW-1:0] a00, a11, a22;
    assign a00 = EW'(m00);
    assign a11 = EW'(m11);
    assign a22 = EW'(m22);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            e_reg[0] <=  a00 - a11 - a22 + ONE;
            e_reg[1] <= -a00 + a11 - a22 + ONE;
            e_reg[2] <= -a00 - a11 + a22 + ONE;
            e_reg[3] <=  a00 + a11 + a22 + ONE;
            sxy_reg  <= PW'(m01) + PW'(m10);
            sxz_reg  <= PW'(m02) + PW'(m20);
            syz_reg  <= PW'(m12) + PW'(m21);
            dx_reg   <= PW'(m21) - PW'(m12);
            dy_reg   <= PW'(m02) - PW'(m20);
            dz_reg   <= PW'(m10) - PW'(m01);
            n_reg    <= n_next;
            side_reg <= side_next;
        end
    end

    function automatic rm2q_pkg::lane_t to_lane(input logic signed [PW-1:0] p);
        rm2q_pkg::lane_t l;
        l.sign = p[PW-1];
        l.mag  = p[PW-1] ? $unsigned(-p) : $unsigned(p);
        return l;
    endfunction

    logic [1:0] best;
    logic signed [EW-1:0] eb;

    always_comb begin
        best = rm2q_pkg::IDX_X;
        eb   = e_reg[0];
        if (e_reg[1] > eb) begin
            best = rm2q_pkg::IDX_Y;
            eb   = e_reg[1];
        end
        if (e_reg[2] > eb) begin
            best = rm2q_pkg::IDX_Z;
            eb   = e_reg[2];
        end
        if (e_reg[3] > eb) begin
            best = rm2q_pkg::IDX_W;
            eb   = e_reg[3];
        end
        side_next.best    = best;
        side_next.invalid = !(eb > 0);
        n_next = side_next.invalid ? '0 :
                 (NW'($unsigned(eb[EW-2:0])) << (FRAC_BITS - 2));
        case (best)
            rm2q_pkg::IDX_X: begin
                side_next.lane[0] = to_lane(sxy_reg);
                side_next.lane[1] = to_lane(sxz_reg);
                side_next.lane[2] = to_lane(dx_reg);
            end
            rm2q_pkg::IDX_Y: begin
                side_next.lane[0] = to_lane(sxy_reg);
                side_next.lane[1] = to_lane(syz_reg);
                side_next.lane[2] = to_lane(dy_reg);
            end
            rm2q_pkg::IDX_Z: begin
                side_next.lane[0] = to_lane(sxz_reg);
                side_next.lane[1] = to_lane(syz_reg);
                side_next.lane[2] = to_lane(dz_reg);
            end
            default: begin
                side_next.lane[0] = to_lane(dx_reg);
                side_next.lane[1] = to_lane(dy_reg);
                side_next.lane[2] = to_lane(dz_reg);
            end
        endcase
    end

    assign out_valid = v2_reg;
    assign n_out     = n_reg;
    assign side_out  = side_reg;
endmodule

// ===== hw/rtl/rm2q_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rm2q_sqrt #(
    parameter int NW = 31,
    parameter int H  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [NW-1:0] n_in,
    input  rm2q_pkg::side_t side_in,
    output logic out_valid,
    output logic [H-1:0] root,
    output rm2q_pkg::side_t side_out
);
    logic            vld_reg  [H];
    logic [NW-1:0]   n_reg    [H];
    logic [NW-1:0]   res_reg  [H];
    rm2q_pkg::side_t side_reg [H];

    genvar j;
    generate
        for (j = 0; j < H; j++) begin : g_stage
            localparam logic [NW:0] BIT = (NW + 1)'(1) << (2 * (H - 1 - j));
            logic [NW-1:0] n_prev, res_prev, n_next, res_next;
            logic [NW:0] trial;
            logic v_prev;
            rm2q_pkg::side_t s_prev;

            if (j == 0) begin : g_first
                assign n_prev   = n_in;
                assign res_prev = '0;
                assign v_prev   = in_valid;
                assign s_prev   = side_in;
            end else begin : g_rest
                assign n_prev   = n_reg[j-1];
                assign res_prev = res_reg[j-1];
                assign v_prev   = vld_reg[j-1];
                assign s_prev   = side_reg[j-1];
            end

            always_comb begin
                trial = {1'b0, res_prev} + BIT;
                if ({1'b0, n_prev} >= trial) begin
                    n_next   = n_prev - trial[NW-1:0];
                    res_next = (res_prev >> 1) + BIT[NW-1:0];
                end else begin
                    n_next   = n_prev;
                    res_next = res_prev >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    vld_reg[j] <= 1'b0;
                end else if (en) begin
                    vld_reg[j] <= v_prev;
                end
            end

            always_ff @(posedge clk) begin
                if (en) begin
                    n_reg[j]    <= n_next;
                    res_reg[j]  <= res_next;
                    side_reg[j] <= s_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[H-1];
    assign root      = res_reg[H-1][H-1:0];
    assign side_out  = side_reg[H-1];
endmodule

// ===== hw/rtl/rm2q_div.sv =====
// Pipelined rounding divider for one off-diagonal component, one quotient bit per stage.
`timescale 1ns / 1ps
module rm2q_div #(
    parameter int FRAC_BITS = 14,
    parameter int VW = 16
) (
    input  logic clk,
    input  logic en,
    input  logic [rm2q_pkg::PAIR_W-1:0] mag,
    input  logic [VW-1:0] v,
    output logic [rm2q_pkg::QUOT_BITS-1:0] quot,
    output logic ovf
);
    localparam int QB = rm2q_pkg::QUOT_BITS;
    localparam int A  = rm2q_pkg::PAIR_W + FRAC_BITS;
    localparam int B  = VW + 2 + QB;
    localparam int RW = (A > B ? A : B) + 1;

    logic [RW-1:0] r_reg   [QB+1];
    logic [RW-1:0] den_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          ovf_reg [QB+1];

    logic [RW-1:0] num0, den0;
    assign num0 = (RW'(mag) << FRAC_BITS) + (RW'(v) << 1);
    assign den0 = RW'(v) << 2;

    always_ff @(posedge clk) begin
        if (en) begin
            r_reg[0]   <= num0;
            den_reg[0] <= den0;
            q_reg[0]   <= '0;
            ovf_reg[0] <= num0 >= (den0 << QB);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QB; k++) begin : g_bit
            logic [RW-1:0] sh;
            assign sh = den_reg[k-1] << (QB - k);
            always_ff @(posedge clk) begin
                if (en) begin
                    den_reg[k] <= den_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                    if (r_reg[k-1] >= sh) begin
                        r_reg[k] <= r_reg[k-1] - sh;
                        q_reg[k] <= q_reg[k-1] | (QB'(1) << (QB - k));
                    end else begin
                        r_reg[k] <= r_reg[k-1];
                        q_reg[k] <= q_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    assign quot = q_reg[QB];
    assign ovf  = ovf_reg[QB];
endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Top level of the pipelined rotation matrix to quaternion converter.
//
// Channel  Role   Carries
// matrix   sink   m00 .. m22, signed Q2.14 matrix entries
// quat     source quat_x/y/z/w, largest_index, invalid
//
// One matrix is taken every cycle unless the output stalls. The path holds the select
// stages, H = (NW+1)/2 square root stages (16 at FRAC_BITS 14) of the bit-per-stage
// root, the 19 stage dividers and the output register. Reset clears only the valid
// bits. When the output request is held, all stages hold and matrix.ready falls.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input logic clk,
    input logic rst_n,
    rm2q_mat_if.sink    matrix,
    rm2q_quat_if.source quat
);
    localparam int EW = (FRAC_BITS > 17 ? FRAC_BITS : 17) + 3;
    localparam int NW = EW + FRAC_BITS - 3;
    localparam int H  = (NW + 1) / 2;
    localparam int DL = rm2q_pkg::QUOT_BITS + 1;

    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || quat.ready;
    assign matrix.ready = en;

    logic sel_valid, sq_valid;
    logic [NW-1:0] n_val;
    rm2q_pkg::side_t sel_side, sq_side;
    logic [H-1:0] root;

    rm2q_select #(.FRAC_BITS(FRAC_BITS), .EW(EW), .NW(NW)) u_select (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(matrix.valid),
        .m00(matrix.m00), .m01(matrix.m01), .m02(matrix.m02),
        .m10(matrix.m10), .m11(matrix.m11), .m12(matrix.m12),
        .m20(matrix.m20), .m21(matrix.m21), .m22(matrix.m22),
        .out_valid(sel_valid), .n_out(n_val), .side_out(sel_side)
    );

    rm2q_sqrt #(.NW(NW), .H(H)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sel_valid),
        .n_in(n_val), .side_in(sel_side),
        .out_valid(sq_valid), .root(root), .side_out(sq_side)
    );

    logic [rm2q_pkg::QUOT_BITS-1:0] quot [3];
    logic ovf [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            rm2q_div #(.FRAC_BITS(FRAC_BITS), .VW(H)) u_div (
                .clk(clk), .en(en), .mag(sq_side.lane[g].mag), .v(root),
                .quot(quot[g]), .ovf(ovf[g])
            );
        end
    endgenerate

    rm2q_pkg::meta_t meta_in;
    rm2q_pkg::meta_t dly_reg [DL];
    logic            dly_vld_reg [DL];

    always_comb
    begin
        meta_in.sign    = {sq_side.lane[2].sign, sq_side.lane[1].sign, sq_side.lane[0].sign};
        meta_in.best    = sq_side.best;
        meta_in.invalid = sq_side.invalid;
        meta_in.vq      = (32'(root) > 32'(32767)) ? 16'h7FFF : 16'(root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DL; i++)
            begin
                dly_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            dly_vld_reg[0] <= sq_valid;
            for (int i = 1; i < DL; i++)
            begin
                dly_vld_reg[i] <= dly_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= meta_in;
            for (int i = 1; i < DL; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    rm2q_pkg::meta_t mt;
    assign mt = dly_reg[DL-1];

    logic signed [15:0] l0, l1, l2, vq;
    logic signed [15:0] x_next, y_next, z_next, w_next;
    logic [1:0] idx_next;
    logic signed [15:0] x_reg, y_reg, z_reg, w_reg;
    logic [1:0] idx_reg;
    logic inv_reg;

    always_comb
    begin
        l0 = rm2q_pkg::sat_lane(mt.sign[0], quot[0], ovf[0]);
        l1 = rm2q_pkg::sat_lane(mt.sign[1], quot[1], ovf[1]);
        l2 = rm2q_pkg::sat_lane(mt.sign[2], quot[2], ovf[2]);
        vq = $signed(mt.vq);
        idx_next = mt.best;
        case (mt.best)
            rm2q_pkg::IDX_X:
            begin
                x_next = vq; y_next = l0; z_next = l1; w_next = l2;
            end
            rm2q_pkg::IDX_Y:
            begin
                x_next = l0; y_next = vq; z_next = l1; w_next = l2;
            end
            rm2q_pkg::IDX_Z:
            begin
                x_next = l0; y_next = l1; z_next = vq; w_next = l2;
            end
            default:
            begin
                x_next = l0; y_next = l1; z_next = l2; w_next = vq;
            end
        endcase
        if (mt.invalid)
        begin
            x_next = '0; y_next = '0; z_next = '0; w_next = '0;
            idx_next = rm2q_pkg::IDX_X;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dly_vld_reg[DL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            w_reg   <= w_next;
            idx_reg <= idx_next;
            inv_reg <= mt.invalid;
        end
    end

    assign quat.valid         = out_valid_reg;
    assign quat.quat_x        = x_reg;
    assign quat.quat_y        = y_reg;
    assign quat.quat_z        = z_reg;
    assign quat.quat_w        = w_reg;
    assign quat.largest_index = idx_reg;
    assign quat.invalid       = inv_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && quat.invalid |-> quat.quat_x == 0 && quat.quat_y == 0 &&
        quat.quat_z == 0 && quat.quat_w == 0 && quat.largest_index == rm2q_pkg::IDX_X)
        else $error("invalid result carries non-zero fields");
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !matrix.ready |-> quat.valid && !quat.ready)
        else $error("input held off without output stall");
    a_winner_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && !quat.invalid |->
        (quat.largest_index != rm2q_pkg::IDX_X || !quat.quat_x[15]) &&
        (quat.largest_index != rm2q_pkg::IDX_Y || !quat.quat_y[15]) &&
        (quat.largest_index != rm2q_pkg::IDX_Z || !quat.quat_z[15]) &&
        (quat.largest_index != rm2q_pkg::IDX_W || !quat.quat_w[15]))
        else $error("largest component is negative");
`endif
endmodule
